FILE: hw/rtl/idet_pkg.sv
// ----------------------------------------------------------------------------
// idet_pkg: shared constants, types and functions
// Widths and index tables for the determinant block.
// ----------------------------------------------------------------------------
`default_nettype none
package idet_pkg;

  localparam int MAX_ORDER = 4;
  localparam int DEPTH     = MAX_ORDER * MAX_ORDER;
  localparam int AW        = 4;
  localparam int EW        = 16;
  localparam int OW        = 3;
  localparam int CW        = 5;
  localparam int PW        = 2 * EW;
  localparam int MW        = PW + 1;
  localparam int TW        = 2 * MW;
  localparam int ACCW      = TW + 2;
  localparam int RW        = 64;

  typedef struct packed {
    logic          pad;
    logic          one;
    logic [AW-1:0] addr;
  } vref_t;

  function automatic logic [1:0] pair_a(input logic [2:0] p);
    logic [1:0] r;
    case (p)
      3'd0, 3'd1, 3'd2: r = 2'd0;
      3'd3, 3'd4:       r = 2'd1;
      default:          r = 2'd2;
    endcase
    return r;
  endfunction

  function automatic logic [1:0] pair_b(input logic [2:0] p);
    logic [1:0] r;
    case (p)
      3'd0:       r = 2'd1;
      3'd1, 3'd3: r = 2'd2;
      default:    r = 2'd3;
    endcase
    return r;
  endfunction

  function automatic logic pair_neg(input logic [2:0] p);
    return (p == 3'd1) || (p == 3'd4);
  endfunction

  function automatic logic [OW-1:0] eff_order(input logic [OW-1:0] o);
    logic [OW-1:0] r;
    if (o == '0) r = OW'(1);
    else if (o > OW'(MAX_ORDER)) r = OW'(MAX_ORDER);
    else r = o;
    return r;
  endfunction

  // The n x n matrix sits in the lower right corner of a 4 x 4 matrix whose
  // upper left block is the identity, which leaves the determinant unchanged.
  function automatic vref_t vmap(input logic [1:0] r, input logic [1:0] c,
                                 input logic [OW-1:0] n);
    vref_t         v;
    logic [OW-1:0] off;
    logic [OW-1:0] rr;
    logic [OW-1:0] cc;
    logic [5:0]    lin;
    off = OW'(MAX_ORDER) - n;
    rr  = {1'b0, r};
    cc  = {1'b0, c};
    v.pad  = (rr < off) || (cc < off);
    v.one  = (r == c);
    lin    = 6'((rr - off) * n) + 6'(cc - off);
    v.addr = lin[AW-1:0];
    return v;
  endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/idet_store.sv
// ----------------------------------------------------------------------------
// idet_store: matrix element memory
// One write port and two registered read ports.
// ----------------------------------------------------------------------------
`default_nettype none
module idet_store (
  input  wire logic                              clk,
  input  wire logic                              we,
  input  wire logic [idet_pkg::AW-1:0]           waddr,
  input  wire logic signed [idet_pkg::EW-1:0]    wdata,
  input  wire logic [idet_pkg::AW-1:0]           raddr0,
  input  wire logic [idet_pkg::AW-1:0]           raddr1,
  output logic signed [idet_pkg::EW-1:0]         rdata0,
  output logic signed [idet_pkg::EW-1:0]         rdata1
);

  logic signed [idet_pkg::EW-1:0] mem [idet_pkg::DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata0 <= mem[raddr0];
    rdata1 <= mem[raddr1];
  end

endmodule
`default_nettype wire

FILE: hw/rtl/integer_determinant.sv
// ----------------------------------------------------------------------------
// integer_determinant: exact determinant of a square integer matrix
// Elements are loaded one per cycle while busy is low; the matrix is then expanded by 2x2 minors.
// ----------------------------------------------------------------------------
// An element is transferred when start is high and busy is low.
// After the last element, busy stays high through ST_MINOR, which forms the twelve
// 2x2 minors on one 16x16 multiplier fed by the two store read ports, ST_PROD for
// the six minor products and ST_DONE to saturate; done then pulses for one cycle.
// The receiver cannot stall. Reset clears the load count and sets order 3.
`default_nettype none
module integer_determinant (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           start,
  output logic                                busy,
  input  wire logic signed [idet_pkg::EW-1:0] element,
  input  wire logic                           cfg_we,
  input  wire logic [idet_pkg::OW-1:0]        cfg_wdata,
  output logic                                done,
  output logic signed [idet_pkg::RW-1:0]      determinant,
  output logic                                overflow
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_MINOR = 2'd1;
  localparam logic [1:0] ST_PROD  = 2'd2;
  localparam logic [1:0] ST_DONE  = 2'd3;

  logic [1:0]                      state;
  logic [idet_pkg::OW-1:0]         matrix_order;
  logic [idet_pkg::OW-1:0]         n_reg;
  logic [idet_pkg::CW-1:0]         load_count;
  logic [idet_pkg::CW-1:0]         k;
  logic [2:0]                      pcnt;
  logic                            c_valid;
  logic                            c_h;
  logic                            c_top;
  idet_pkg::vref_t                 c_x;
  idet_pkg::vref_t                 c_y;
  logic signed [idet_pkg::PW-1:0]  first;
  logic signed [idet_pkg::MW-1:0]  top_m [6];
  logic signed [idet_pkg::MW-1:0]  bot_m [6];
  logic signed [idet_pkg::ACCW-1:0] acc;

  logic                            accept;
  logic [idet_pkg::OW-1:0]         n_now;
  logic [idet_pkg::CW-1:0]         count_next;
  logic [idet_pkg::CW-1:0]         need;
  logic [3:0]                      j;
  logic                            top;
  logic [2:0]                      p;
  logic [1:0]                      r0;
  logic [1:0]                      a;
  logic [1:0]                      b;
  idet_pkg::vref_t                 vx;
  idet_pkg::vref_t                 vy;
  logic signed [idet_pkg::EW-1:0]  rd0;
  logic signed [idet_pkg::EW-1:0]  rd1;
  logic signed [idet_pkg::EW-1:0]  opx;
  logic signed [idet_pkg::EW-1:0]  opy;
  logic signed [idet_pkg::PW-1:0]  prod;
  logic signed [idet_pkg::MW-1:0]  minor_val;
  logic signed [idet_pkg::TW-1:0]  term;
  logic                            fits;

  assign busy       = (state != ST_IDLE);
  assign accept     = start && !busy;
  assign n_now      = idet_pkg::eff_order(matrix_order);
  assign count_next = load_count + idet_pkg::CW'(1);
  assign need       = idet_pkg::CW'(n_now * n_now);

  always_comb begin
    j   = k[4:1];
    top = (j < 4'd6);
    p   = top ? j[2:0] : 3'(4'd11 - j);
    r0  = top ? 2'd0 : 2'd2;
    a   = idet_pkg::pair_a(p);
    b   = idet_pkg::pair_b(p);
    if (!k[0]) begin
      vx = idet_pkg::vmap(r0, a, n_reg);
      vy = idet_pkg::vmap(r0 + 2'd1, b, n_reg);
    end else begin
      vx = idet_pkg::vmap(r0, b, n_reg);
      vy = idet_pkg::vmap(r0 + 2'd1, a, n_reg);
    end
  end

  idet_store u_store (
    .clk    (clk),
    .we     (accept),
    .waddr  (load_count[idet_pkg::AW-1:0]),
    .wdata  (element),
    .raddr0 (vx.addr),
    .raddr1 (vy.addr),
    .rdata0 (rd0),
    .rdata1 (rd1)
  );

  always_comb begin
    opx       = c_x.pad ? idet_pkg::EW'(c_x.one) : rd0;
    opy       = c_y.pad ? idet_pkg::EW'(c_y.one) : rd1;
    prod      = idet_pkg::PW'(opx * opy);
    minor_val = idet_pkg::MW'(first) - idet_pkg::MW'(prod);
    term      = idet_pkg::TW'(top_m[0] * bot_m[0]);
    fits      = (acc[idet_pkg::ACCW-1:idet_pkg::RW-1] == '0) ||
                (acc[idet_pkg::ACCW-1:idet_pkg::RW-1] == '1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      matrix_order <= idet_pkg::OW'(3);
      load_count   <= '0;
      c_valid      <= 1'b0;
      done         <= 1'b0;
    end else begin
      done <= 1'b0;
      if (cfg_we) begin
        matrix_order <= cfg_wdata;
      end
      c_valid <= (state == ST_MINOR) && (k < idet_pkg::CW'(24));
      case (state)
        ST_IDLE: begin
          if (accept) begin
            if (count_next >= need) begin
              load_count <= '0;
              n_reg      <= n_now;
              k          <= '0;
              state      <= ST_MINOR;
            end else begin
              load_count <= count_next;
            end
          end
        end
        ST_MINOR: begin
          k <= k + idet_pkg::CW'(1);
          if (k == idet_pkg::CW'(24)) begin
            pcnt  <= '0;
            state <= ST_PROD;
          end
        end
        ST_PROD: begin
          pcnt <= pcnt + 3'd1;
          if (pcnt == 3'd5) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          done  <= 1'b1;
          state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    c_h   <= k[0];
    c_top <= top;
    c_x   <= vx;
    c_y   <= vy;
    if (c_valid) begin
      if (!c_h) begin
        first <= prod;
      end else if (c_top) begin
        top_m[5] <= minor_val;
        for (int i = 0; i < 5; i++) top_m[i] <= top_m[i+1];
      end else begin
        bot_m[5] <= minor_val;
        for (int i = 0; i < 5; i++) bot_m[i] <= bot_m[i+1];
      end
    end
    if ((state == ST_MINOR) && (k == idet_pkg::CW'(24))) begin
      acc <= '0;
    end
    if (state == ST_PROD) begin
      if (idet_pkg::pair_neg(pcnt)) begin
        acc <= acc - idet_pkg::ACCW'(term);
      end else begin
        acc <= acc + idet_pkg::ACCW'(term);
      end
      for (int i = 0; i < 5; i++) begin
        top_m[i] <= top_m[i+1];
        bot_m[i] <= bot_m[i+1];
      end
    end
    if (state == ST_DONE) begin
      overflow <= !fits;
      if (fits) begin
        determinant <= acc[idet_pkg::RW-1:0];
      end else if (acc[idet_pkg::ACCW-1]) begin
        determinant <= {1'b1, {(idet_pkg::RW-1){1'b0}}};
      end else begin
        determinant <= {1'b0, {(idet_pkg::RW-1){1'b1}}};
      end
    end
  end

endmodule
`default_nettype wire
